// ===== design/pcu_pkg.sv =====
// pcu_pkg: shared types and constants for the performance counter unit.
// Holds counter indexes, instruction decode constants and the queue entry type.
// No dependencies.
package pcu_pkg;

    localparam int COUNTER_WIDTH_DEF = 64;
    localparam int NUM_CNT           = 28;
    localparam int SEL_W             = 5;
    localparam int QUEUE_DEPTH       = 2;
    localparam int QPTR_W            = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W            = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        FUNC_CYCLE  = 2'd0,
        FUNC_RETIRE = 2'd1,
        FUNC_READ   = 2'd2,
        FUNC_SPARE  = 2'd3
    } func_t;

    typedef enum logic [SEL_W-1:0] {
        C_ACTIVE    = 5'd0,
        C_BR        = 5'd1,
        C_BR_FAIL   = 5'd2,
        C_B_FAIL    = 5'd3,
        C_J_FAIL    = 5'd4,
        C_FETCH     = 5'd5,
        C_FSTALL    = 5'd6,
        C_SYSHZ     = 5'd7,
        C_ROUHZ     = 5'd8,
        C_EXSTALL   = 5'd9,
        C_MEM       = 5'd10,
        C_IMISS     = 5'd11,
        C_IMISS_CYC = 5'd12,
        C_IHIT      = 5'd13,
        C_IHIT_CYC  = 5'd14,
        C_INSTR     = 5'd15,
        C_LD        = 5'd16,
        C_ST        = 5'd17,
        C_ALU       = 5'd18,
        C_BINST     = 5'd19,
        C_JAL       = 5'd20,
        C_JALR      = 5'd21,
        C_CSR       = 5'd22,
        C_OTHER     = 5'd23,
        C_CALL      = 5'd24,
        C_RET       = 5'd25,
        C_SNAP_CYC  = 5'd26,
        C_SNAP_INST = 5'd27
    } cnt_idx_t;

    typedef enum logic [6:0] {
        OP_LOAD   = 7'b0000011,
        OP_STORE  = 7'b0100011,
        OP_BRANCH = 7'b1100011,
        OP_SYSTEM = 7'b1110011,
        OP_ALU    = 7'b0110011,
        OP_ALUI   = 7'b0010011,
        OP_JAL    = 7'b1101111,
        OP_JALR   = 7'b1100111
    } opcode_t;

    localparam logic [31:0] INST_FENCE    = 32'h0ff0000f;
    localparam logic [31:0] INST_MACH_RET = 32'h30200073;
    localparam logic [31:0] INST_SUPV_RET = 32'h10200073;
    localparam logic [31:0] INST_RET      = 32'h00008067;

    localparam logic [2:0] IC_IDLE        = 3'd0;
    localparam logic [2:0] IC_REFILL_DONE = 3'd3;

    // One classified beat: plain increments, what the miss tracker needs, the fence flag and the counter select.
    typedef struct packed {
        logic [NUM_CNT-1:0] inc;
        logic               is_cycle;
        logic               fetched;
        logic               hit;
        logic               ist_idle;
        logic               ist_done;
        logic               fence;
        logic [SEL_W-1:0]   sel;
    } pcu_entry_t;

endpackage

// ===== design/pcu_front.sv =====
// pcu_front: classifies an incoming beat into per-counter increment flags.
// Depends on pcu_pkg.
module pcu_front (
    input  logic [1:0]          func,
    input  logic                core_in_reset,
    input  logic [3:0]          wb_flags,
    input  logic [5:0]          pipe_flags,
    input  logic [2:0]          icache_state,
    input  logic [31:0]         inst_word,
    input  logic [4:0]          counter_select,
    output pcu_pkg::pcu_entry_t entry
);
    import pcu_pkg::*;

    logic    do_cycle;
    logic    do_retire;
    logic    wb_live, br, jmp, flush;
    logic    hit, sys_hz, dec_rdy, rob_rdy, ex_rdy, mem;
    logic    fetched;
    opcode_t opc;

    assign do_cycle  = !core_in_reset && (func_t'(func) == FUNC_CYCLE);
    assign do_retire = !core_in_reset && (func_t'(func) == FUNC_RETIRE);

    assign wb_live  = wb_flags[0];
    assign br       = wb_flags[1];
    assign jmp      = wb_flags[2];
    assign flush    = wb_flags[3];
    assign hit      = pipe_flags[0];
    assign sys_hz   = pipe_flags[1];
    assign dec_rdy  = pipe_flags[2];
    assign rob_rdy  = pipe_flags[3];
    assign ex_rdy   = pipe_flags[4];
    assign mem      = pipe_flags[5];
    assign fetched  = hit && dec_rdy;
    assign opc      = opcode_t'(inst_word[6:0]);

    always_comb
    begin
        entry          = '0;
        entry.sel      = counter_select;
        entry.is_cycle = do_cycle;
        entry.fetched  = fetched;
        entry.hit      = hit;
        entry.ist_idle = (icache_state == IC_IDLE);
        entry.ist_done = (icache_state == IC_REFILL_DONE);
        entry.fence    = do_retire && (inst_word == INST_FENCE);

        if (do_cycle)
        begin
            entry.inc[C_ACTIVE]  = 1'b1;
            entry.inc[C_BR]      = wb_live && (br || jmp);
            entry.inc[C_BR_FAIL] = wb_live && (br || jmp) && flush;
            entry.inc[C_B_FAIL]  = wb_live && flush && br;
            entry.inc[C_J_FAIL]  = wb_live && flush && jmp;
            entry.inc[C_FETCH]   = fetched;
            entry.inc[C_FSTALL]  = !hit && dec_rdy;
            entry.inc[C_SYSHZ]   = sys_hz;
            entry.inc[C_ROUHZ]   = !rob_rdy;
            entry.inc[C_EXSTALL] = !ex_rdy;
            entry.inc[C_MEM]     = mem;
        end

        if (do_retire)
        begin
            entry.inc[C_INSTR] = 1'b1;
            case (opc)
                OP_LOAD:   entry.inc[C_LD]    = 1'b1;
                OP_STORE:  entry.inc[C_ST]    = 1'b1;
                OP_ALU,
                OP_ALUI:   entry.inc[C_ALU]   = 1'b1;
                OP_BRANCH: entry.inc[C_BINST] = 1'b1;
                OP_JAL:
                begin
                    entry.inc[C_JAL]  = 1'b1;
                    entry.inc[C_CALL] = (inst_word[11:7] != 5'd0);
                end
                OP_JALR:
                begin
                    entry.inc[C_JALR] = 1'b1;
                    entry.inc[C_CALL] = (inst_word[11:7] != 5'd0);
                end
                OP_SYSTEM: entry.inc[C_CSR]   = 1'b1;
                default:   entry.inc[C_OTHER] = 1'b1;
            endcase
            entry.inc[C_RET] = (inst_word == INST_MACH_RET) || (inst_word == INST_SUPV_RET)
                            || (inst_word == INST_RET);
        end
    end

endmodule

// ===== design/pcu_queue.sv =====
// pcu_queue: small FIFO of classified beats between front and back.
// Depends on pcu_pkg.
module pcu_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pcu_pkg::pcu_entry_t push_data,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output pcu_pkg::pcu_entry_t pop_data
);
    import pcu_pkg::*;

    pcu_entry_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/pcu_back.sv =====
// pcu_back: counter bank, miss tracker and result register.
// Depends on pcu_pkg.
module pcu_back #(
    parameter int COUNTER_WIDTH = pcu_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     entry_valid,
    input  pcu_pkg::pcu_entry_t      entry,
    output logic                     entry_take,
    output logic                     result_valid,
    input  logic                     result_stall,
    output logic [COUNTER_WIDTH-1:0] counter_value
);
    import pcu_pkg::*;

    logic [COUNTER_WIDTH-1:0] cnt_reg [NUM_CNT];
    logic [COUNTER_WIDTH-1:0] cnt_next [NUM_CNT];
    logic                     mip_reg, mip_next;
    logic                     out_valid_reg, out_valid_next;
    logic [COUNTER_WIDTH-1:0] value_reg, value_next;
    logic                     miss_start;
    logic                     miss_cont;
    logic [COUNTER_WIDTH-1:0] hit_count;

    assign entry_take = entry_valid && (!out_valid_reg || !result_stall);

    assign miss_start = entry.is_cycle && !mip_reg && !entry.fetched && entry.ist_idle;
    assign miss_cont  = entry.is_cycle && mip_reg && !(entry.hit && entry.ist_done);
    // new miss implies no fetch this beat: hits = fetches - (misses + 1)
    assign hit_count  = cnt_reg[C_FETCH] + ~cnt_reg[C_IMISS];

    always_comb
    begin
        for (int i = 0; i < NUM_CNT; i++)
        begin
            cnt_next[i] = entry.inc[i] ? cnt_reg[i] + COUNTER_WIDTH'(1) : cnt_reg[i];
        end
        if (miss_start)
        begin
            cnt_next[C_IMISS]     = cnt_reg[C_IMISS] + COUNTER_WIDTH'(1);
            cnt_next[C_IMISS_CYC] = cnt_reg[C_IMISS_CYC] + COUNTER_WIDTH'(1);
            cnt_next[C_IHIT]      = hit_count;
            cnt_next[C_IHIT_CYC]  = hit_count;
        end
        else if (miss_cont)
        begin
            cnt_next[C_IMISS_CYC] = cnt_reg[C_IMISS_CYC] + COUNTER_WIDTH'(1);
        end
        if (entry.fence)
        begin
            cnt_next[C_SNAP_CYC]  = cnt_reg[C_ACTIVE];
            cnt_next[C_SNAP_INST] = cnt_reg[C_INSTR] + COUNTER_WIDTH'(1);
        end

        mip_next = mip_reg;
        if (entry.is_cycle)
        begin
            mip_next = mip_reg ? miss_cont : miss_start;
        end

        value_next = (entry.sel < SEL_W'(NUM_CNT)) ? cnt_next[entry.sel] : '0;

        out_valid_next = out_valid_reg;
        if (entry_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CNT; i++)
            begin
                cnt_reg[i] <= '0;
            end
            mip_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (entry_take)
            begin
                for (int i = 0; i < NUM_CNT; i++)
                begin
                    cnt_reg[i] <= cnt_next[i];
                end
                mip_reg <= mip_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (entry_take)
        begin
            value_reg <= value_next;
        end
    end

    assign result_valid  = out_valid_reg;
    assign counter_value = value_reg;

endmodule

// ===== design/perf_counter_unit.sv =====
// perf_counter_unit: processor performance counter block, top level.
// Instantiates pcu_front, pcu_queue and pcu_back; depends on pcu_pkg.
//
//   channel | handshake                  | payload
//   item    | item_valid / item_stall    | func, core_in_reset, wb_flags, pipe_flags,
//           |                            | icache_state, inst_word, counter_select
//   result  | result_valid / result_stall| counter_value
//
// One beat per clock sustained while result_stall is low; an accepted item passes through a
// queue slot, then the counter bank update into the result register, which drives result_valid.
// The counter bank updates one queued beat per cycle whenever the result register is free.
// item_stall rises only when the two-entry queue is full.
// Reset clears all counters, the miss tracker and the queue.
module perf_counter_unit #(
    parameter int COUNTER_WIDTH = pcu_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_stall,
    input  logic [1:0]               func,
    input  logic                     core_in_reset,
    input  logic [3:0]               wb_flags,
    input  logic [5:0]               pipe_flags,
    input  logic [2:0]               icache_state,
    input  logic [31:0]              inst_word,
    input  logic [4:0]               counter_select,
    output logic                     result_valid,
    input  logic                     result_stall,
    output logic [COUNTER_WIDTH-1:0] counter_value
);
    import pcu_pkg::*;

    pcu_entry_t front_entry;
    pcu_entry_t back_entry;
    logic       q_full;
    logic       q_not_empty;
    logic       q_pop;
    logic       q_push;

    assign item_stall = q_full;
    assign q_push     = item_valid && !q_full;

    pcu_front u_front (
        .func           (func),
        .core_in_reset  (core_in_reset),
        .wb_flags       (wb_flags),
        .pipe_flags     (pipe_flags),
        .icache_state   (icache_state),
        .inst_word      (inst_word),
        .counter_select (counter_select),
        .entry          (front_entry)
    );

    pcu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (front_entry),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (back_entry)
    );

    pcu_back #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .entry_valid   (q_not_empty),
        .entry         (back_entry),
        .entry_take    (q_pop),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .counter_value (counter_value)
    );

endmodule
